>>> rtl/core/csl_pkg.sv
// ----------------------------------------------------------------------------
// csl_pkg
// shared types and constants of the c subset lexer
// ----------------------------------------------------------------------------
package csl_pkg;

    localparam logic [4:0] K_INT    = 5'd0;
    localparam logic [4:0] K_IF     = 5'd1;
    localparam logic [4:0] K_RETURN = 5'd2;
    localparam logic [4:0] K_LPAR   = 5'd3;
    localparam logic [4:0] K_RPAR   = 5'd4;
    localparam logic [4:0] K_LBR    = 5'd5;
    localparam logic [4:0] K_RBR    = 5'd6;
    localparam logic [4:0] K_PLUS   = 5'd7;
    localparam logic [4:0] K_MINUS  = 5'd8;
    localparam logic [4:0] K_STAR   = 5'd9;
    localparam logic [4:0] K_SLASH  = 5'd10;
    localparam logic [4:0] K_PCT    = 5'd11;
    localparam logic [4:0] K_LT     = 5'd12;
    localparam logic [4:0] K_GT     = 5'd13;
    localparam logic [4:0] K_LE     = 5'd14;
    localparam logic [4:0] K_GE     = 5'd15;
    localparam logic [4:0] K_EQ     = 5'd16;
    localparam logic [4:0] K_NEQ    = 5'd17;
    localparam logic [4:0] K_LOR    = 5'd18;
    localparam logic [4:0] K_LAND   = 5'd19;
    localparam logic [4:0] K_BOR    = 5'd20;
    localparam logic [4:0] K_BAND   = 5'd21;
    localparam logic [4:0] K_XOR    = 5'd22;
    localparam logic [4:0] K_LSH    = 5'd23;
    localparam logic [4:0] K_RSH    = 5'd24;
    localparam logic [4:0] K_SEMI   = 5'd25;
    localparam logic [4:0] K_ASGN   = 5'd26;
    localparam logic [4:0] K_IDENT  = 5'd27;
    localparam logic [4:0] K_ICON   = 5'd28;
    localparam logic [4:0] K_END    = 5'd29;
    localparam logic [4:0] K_ERR    = 5'd30;

    localparam logic [1:0] CAUSE_NONE  = 2'd0;
    localparam logic [1:0] CAUSE_BYTE  = 2'd1;
    localparam logic [1:0] CAUSE_BANG  = 2'd2;

    localparam logic [62:0] VMAX = {63{1'b1}};

    typedef enum logic [3:0] {
        M_IDLE, M_KW, M_ID, M_NUM, M_LT, M_GT, M_EQ, M_BANG, M_BAR, M_AMP
    } t_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic [4:0]  kind;
        logic [62:0] int_value;
        logic [15:0] start_offset;
        logic [16:0] ident_length;
        logic [1:0]  error_cause;
        logic        run_last;
    } t_out_word;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic [15:0] pos;
        logic        letter;
        logic        digit;
        logic        space;
        logic [3:0]  dval;
    } t_cls_word;

endpackage

>>> rtl/core/c_subset_lexer.sv
// ----------------------------------------------------------------------------
// c_subset_lexer
// streaming lexer for a small c subset
// ----------------------------------------------------------------------------
// One program byte per cycle goes in while the queue has room; tokens come
// out one per cycle while the output side is ready. A byte that yields two or
// three tokens (flush plus new token plus end) holds the output register until
// all of them are taken, as the back end has a single token output port.
// A front classifier feeds a two-word queue into the lexer state machine.
module c_subset_lexer
    import csl_pkg::*;
#(
    parameter int unsigned MAX_PROGRAM_BYTES = 65536
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_word,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output t_out_word o_out_word,
    output logic      o_out_valid,
    input  logic      i_out_ready
);
    // identifier length cap, limited to the 17-bit field
    localparam int unsigned LEN_CAP =
        (MAX_PROGRAM_BYTES < 131071) ? MAX_PROGRAM_BYTES : 131071;

    t_cls_word f_cls, q_cls;
    logic      f_valid, f_ready, q_valid, q_ready;

    // front: offset tracking and byte classes
    csl_front u_front (
        .i_clk, .i_rst_n,
        .i_word(i_in_word), .i_valid(i_in_valid), .o_ready(o_in_ready),
        .o_cls(f_cls), .o_valid(f_valid), .i_ready(f_ready)
    );

    // queue decouples the two halves
    csl_queue u_queue (
        .i_clk, .i_rst_n,
        .i_word(f_cls), .i_valid(f_valid), .o_ready(f_ready),
        .o_word(q_cls), .o_valid(q_valid), .i_ready(q_ready)
    );

    // back: lexing state and token output
    csl_back #(.LEN_CAP(LEN_CAP)) u_back (
        .i_clk, .i_rst_n,
        .i_cls(q_cls), .i_valid(q_valid), .o_ready(q_ready),
        .o_word(o_out_word), .o_valid(o_out_valid), .i_ready(i_out_ready)
    );

    // stalled output word must hold
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed under stall");

    // end token always closes its byte's run
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.kind == K_END |-> o_out_word.run_last)
        else $error("end token without run_last");

    // error tokens carry a cause, others none
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_word.kind == K_ERR) == (o_out_word.error_cause != CAUSE_NONE)))
        else $error("error cause mismatch");
endmodule

>>> rtl/core/csl_front.sv
// ----------------------------------------------------------------------------
// csl_front
// accepts bytes, tracks offset and classifies each byte
// ----------------------------------------------------------------------------
module csl_front
    import csl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_word,
    input  logic      i_valid,
    output logic      o_ready,
    output t_cls_word o_cls,
    output logic      o_valid,
    input  logic      i_ready
);
    logic [15:0] r_pos;
    logic        take;

    assign o_ready = i_ready;
    assign o_valid = i_valid;
    assign take    = i_valid && i_ready;

    always_comb begin
        o_cls.ch     = i_word.ch;
        o_cls.last   = i_word.last;
        o_cls.pos    = r_pos;
        o_cls.letter = (i_word.ch >= "a" && i_word.ch <= "z") ||
                       (i_word.ch >= "A" && i_word.ch <= "Z");
        o_cls.digit  = i_word.ch >= "0" && i_word.ch <= "9";
        o_cls.space  = i_word.ch == " " || i_word.ch == 8'h09 || i_word.ch == 8'h0a;
        o_cls.dval   = 4'(i_word.ch - "0");
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (take) begin
            r_pos <= i_word.last ? 16'd0 : r_pos + 16'd1;
        end
    end
endmodule

>>> rtl/core/csl_queue.sv
// ----------------------------------------------------------------------------
// csl_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module csl_queue
    import csl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cls_word i_word,
    input  logic      i_valid,
    output logic      o_ready,
    output t_cls_word o_word,
    output logic      o_valid,
    input  logic      i_ready
);
    t_cls_word   r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_word  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

>>> rtl/core/csl_back.sv
// ----------------------------------------------------------------------------
// csl_back
// lexer state machine; while the output is ready, emits up to three tokens per byte, one per cycle
// ----------------------------------------------------------------------------
module csl_back
    import csl_pkg::*;
#(
    parameter int unsigned LEN_CAP = 65536
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cls_word i_cls,
    input  logic      i_valid,
    output logic      o_ready,
    output t_out_word o_word,
    output logic      o_valid,
    input  logic      i_ready
);
    localparam logic [16:0] CAP = 17'(LEN_CAP);

    t_mode       r_mode;
    logic [2:0]  r_prog;
    logic [2:0]  r_cand;
    logic [15:0] r_start;
    logic [16:0] r_len;
    logic [62:0] r_acc;
    logic        r_err;
    // pending tokens of the current byte
    t_out_word   r_tok [3];
    logic [1:0]  r_cnt;
    logic [1:0]  r_idx;
    // saturation limit for the incoming digit
    logic [62:0] sat_lim;

    t_out_word   n_tok [3];
    logic [1:0]  n_cnt;
    t_mode       n_mode;
    logic [2:0]  n_prog, n_cand;
    logic [15:0] n_start;
    logic [16:0] n_len;
    logic [62:0] n_acc;
    logic        n_err;

    logic busy, take;
    assign busy    = r_cnt != 2'd0;
    assign o_valid = busy;
    assign o_word  = r_tok[r_idx];
    assign o_ready = !busy || (i_ready && r_idx == r_cnt - 2'd1);
    assign take    = i_valid && o_ready;
    // literal saturation limit (vmax - d) / 10 via small table over the digit
    always_comb begin
        unique case (i_cls.dval)
            4'd0: sat_lim = (VMAX - 63'd0) / 63'd10;
            4'd1: sat_lim = (VMAX - 63'd1) / 63'd10;
            4'd2: sat_lim = (VMAX - 63'd2) / 63'd10;
            4'd3: sat_lim = (VMAX - 63'd3) / 63'd10;
            4'd4: sat_lim = (VMAX - 63'd4) / 63'd10;
            4'd5: sat_lim = (VMAX - 63'd5) / 63'd10;
            4'd6: sat_lim = (VMAX - 63'd6) / 63'd10;
            4'd7: sat_lim = (VMAX - 63'd7) / 63'd10;
            4'd8: sat_lim = (VMAX - 63'd8) / 63'd10;
            4'd9: sat_lim = (VMAX - 63'd9) / 63'd10;
            default: sat_lim = VMAX;
        endcase
    end

    function automatic logic kw_char(input logic [1:0] k, input logic [2:0] p,
                                     input logic [7:0] c);
        logic [7:0] e;
        e = 8'h00;
        unique case (k)
            2'd0: e = (p == 3'd1) ? "n" : (p == 3'd2) ? "t" : 8'h00;
            2'd1: e = (p == 3'd1) ? "f" : 8'h00;
            default: begin
                unique case (p)
                    3'd1: e = "e";
                    3'd2: e = "t";
                    3'd3: e = "u";
                    3'd4: e = "r";
                    3'd5: e = "n";
                    default: e = 8'h00;
                endcase
            end
        endcase
        return e == c && e != 8'h00;
    endfunction

    always_comb begin
        t_out_word t;
        logic      flush, start, stop;
        logic [2:0] keep;
        logic [2:0] pp;
        logic [4:0] sk;
        logic       skv;
        t = '0;
        for (int i = 0; i < 3; i++) n_tok[i] = '0;
        n_cnt = '0;
        n_mode = r_mode; n_prog = r_prog; n_cand = r_cand; n_start = r_start;
        n_len = r_len; n_acc = r_acc; n_err = r_err;
        flush = 1'b0; start = 1'b0; stop = 1'b0;
        keep = '0; pp = r_prog + 3'd1; sk = K_SEMI; skv = 1'b0;

        if (!r_err) begin
            unique case (r_mode)
                M_KW: begin
                    if (i_cls.letter) begin
                        stop = 1'b1;
                        for (int i = 0; i < 3; i++)
                            keep[i] = r_cand[i] && kw_char(2'(i), r_prog, i_cls.ch);
                        n_len = r_len + 17'd1;
                        if (keep == 3'd0) n_mode = M_ID;
                        else begin
                            n_cand = keep;
                            n_prog = pp;
                            if ((keep[0] && pp == 3'd3) || (keep[1] && pp == 3'd2) ||
                                (keep[2] && pp == 3'd6)) begin
                                t = '0;
                                t.kind = keep[0] && pp == 3'd3 ? K_INT :
                                         keep[1] && pp == 3'd2 ? K_IF : K_RETURN;
                                t.start_offset = r_start;
                                n_tok[n_cnt] = t; n_cnt = n_cnt + 2'd1;
                                n_mode = M_IDLE;
                            end
                        end
                    end else flush = 1'b1;
                end
                M_ID: begin
                    if (i_cls.letter) begin
                        stop = 1'b1;
                        if (r_len < CAP) n_len = r_len + 17'd1;
                    end else flush = 1'b1;
                end
                M_NUM: begin
                    if (i_cls.digit) begin
                        stop = 1'b1;
                        if (r_acc > sat_lim) n_acc = VMAX;
                        else n_acc = 63'(r_acc * 63'd10) + 63'(i_cls.dval);
                    end else flush = 1'b1;
                end
                M_LT, M_GT: begin
                    if (i_cls.ch == "=" || i_cls.ch == (r_mode == M_LT ? "<" : ">")) begin
                        stop = 1'b1; t = '0; t.start_offset = r_start;
                        t.kind = (i_cls.ch == "=") ? (r_mode == M_LT ? K_LE : K_GE)
                                                   : (r_mode == M_LT ? K_LSH : K_RSH);
                        n_tok[n_cnt] = t; n_cnt = n_cnt + 2'd1; n_mode = M_IDLE;
                    end else flush = 1'b1;
                end
                M_EQ, M_BAR, M_AMP: begin
                    if (i_cls.ch == (r_mode == M_EQ ? "=" : r_mode == M_BAR ? "|" : "&")) begin
                        stop = 1'b1; t = '0; t.start_offset = r_start;
                        t.kind = r_mode == M_EQ ? K_EQ : r_mode == M_BAR ? K_LOR : K_LAND;
                        n_tok[n_cnt] = t; n_cnt = n_cnt + 2'd1; n_mode = M_IDLE;
                    end else flush = 1'b1;
                end
                M_BANG: begin
                    stop = 1'b1; t = '0; t.start_offset = r_start;
                    if (i_cls.ch == "=") t.kind = K_NEQ;
                    else begin
                        t.kind = K_ERR; t.error_cause = CAUSE_BANG; n_err = 1'b1;
                    end
                    n_tok[n_cnt] = t; n_cnt = n_cnt + 2'd1; n_mode = M_IDLE;
                end
                default: begin
                    n_mode = M_IDLE; flush = 1'b1;
                end
            endcase

            // pending token as it stands, then begin a new one
            if (flush) begin
                t = '0; t.start_offset = r_start;
                unique case (r_mode)
                    M_KW, M_ID: begin t.kind = K_IDENT; t.ident_length = r_len; end
                    M_NUM: begin t.kind = K_ICON; t.int_value = r_acc; end
                    M_LT:  t.kind = K_LT;
                    M_GT:  t.kind = K_GT;
                    M_EQ:  t.kind = K_ASGN;
                    M_BAR: t.kind = K_BOR;
                    M_AMP: t.kind = K_BAND;
                    default: t.kind = K_END;
                endcase
                if (r_mode != M_IDLE) begin
                    n_tok[n_cnt] = t; n_cnt = n_cnt + 2'd1;
                end
                n_mode = M_IDLE;
                start = 1'b1;
            end
            if (start && !stop) begin
                n_start = i_cls.pos;
                if (i_cls.space) begin
                    n_mode = M_IDLE;
                end else if (i_cls.letter) begin
                    n_len = 17'd1; n_prog = 3'd1;
                    if (i_cls.ch == "i") begin n_cand = 3'd3; n_mode = M_KW; end
                    else if (i_cls.ch == "r") begin n_cand = 3'd4; n_mode = M_KW; end
                    else begin n_cand = 3'd0; n_mode = M_ID; end
                end else if (i_cls.digit) begin
                    n_acc = 63'(i_cls.dval); n_mode = M_NUM;
                end else begin
                    skv = 1'b1;
                    unique case (i_cls.ch)
                        "(": sk = K_LPAR;
                        ")": sk = K_RPAR;
                        "{": sk = K_LBR;
                        "}": sk = K_RBR;
                        "+": sk = K_PLUS;
                        "-": sk = K_MINUS;
                        "*": sk = K_STAR;
                        "/": sk = K_SLASH;
                        "%": sk = K_PCT;
                        "^": sk = K_XOR;
                        ";": sk = K_SEMI;
                        "<": begin skv = 1'b0; n_mode = M_LT; end
                        ">": begin skv = 1'b0; n_mode = M_GT; end
                        "=": begin skv = 1'b0; n_mode = M_EQ; end
                        "!": begin skv = 1'b0; n_mode = M_BANG; end
                        "|": begin skv = 1'b0; n_mode = M_BAR; end
                        "&": begin skv = 1'b0; n_mode = M_AMP; end
                        default: begin sk = K_ERR; end
                    endcase
                    if (skv) begin
                        t = '0; t.kind = sk; t.start_offset = i_cls.pos;
                        if (sk == K_ERR) begin
                            t.error_cause = CAUSE_BYTE; n_err = 1'b1;
                        end
                        n_tok[n_cnt] = t; n_cnt = n_cnt + 2'd1;
                    end
                end
            end
        end

        if (i_cls.last) begin
            if (!n_err && n_mode != M_IDLE) begin
                t = '0; t.start_offset = n_start;
                unique case (n_mode)
                    M_KW, M_ID: begin t.kind = K_IDENT; t.ident_length = n_len; end
                    M_NUM: begin t.kind = K_ICON; t.int_value = n_acc; end
                    M_LT:  t.kind = K_LT;
                    M_GT:  t.kind = K_GT;
                    M_EQ:  t.kind = K_ASGN;
                    M_BAR: t.kind = K_BOR;
                    M_AMP: t.kind = K_BAND;
                    default: begin t.kind = K_ERR; t.error_cause = CAUSE_BANG; end
                endcase
                n_tok[n_cnt] = t; n_cnt = n_cnt + 2'd1;
            end
            t = '0; t.kind = K_END; t.start_offset = i_cls.pos + 16'd1;
            n_tok[n_cnt] = t; n_cnt = n_cnt + 2'd1;
            n_mode = M_IDLE; n_prog = '0; n_cand = 3'd7; n_start = '0;
            n_len = '0; n_acc = '0; n_err = 1'b0;
        end
        if (n_cnt != 2'd0) n_tok[n_cnt - 2'd1].run_last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_prog <= '0; r_cand <= 3'd7; r_start <= '0;
            r_len <= '0; r_acc <= '0; r_err <= 1'b0; r_cnt <= '0; r_idx <= '0;
        end else begin
            if (busy && i_ready) r_idx <= r_idx + 2'd1;
            if (busy && i_ready && r_idx == r_cnt - 2'd1) r_cnt <= '0;
            if (take) begin
                r_mode <= n_mode; r_prog <= n_prog; r_cand <= n_cand;
                r_start <= n_start; r_len <= n_len; r_acc <= n_acc; r_err <= n_err;
                r_cnt <= n_cnt; r_idx <= '0;
                for (int i = 0; i < 3; i++) r_tok[i] <= n_tok[i];
            end
        end
    end
endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the c subset lexer against a behavioral token predictor
// ----------------------------------------------------------------------------
// Program bytes go in through the valid/ready input channel and tokens come
// back through the output channel. Every accepted byte is run through a
// predictor that keeps its own copy of the lexer state. The tokens it expects
// are queued in a scoreboard, and each token the block sends back is compared
// field by field with the oldest one waiting. Five short directed programs
// come first, then random programs built mostly from well-formed tokens.
// Idle cycles on both sides change from phase to phase.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import csl_pkg::*;

    // scoreboard: expected tokens in arrival order
    class token_board;
        t_out_word pending_q[$];
        int        n_errors;

        // a lone bang latches an error but lexing stops there
        t_mode      mode;
        logic [2:0] kw_progress;
        logic [2:0] kw_open;
        logic [15:0] seg_start;
        logic [16:0] seg_len;
        logic [62:0] accum;
        logic [15:0] byte_pos;
        bit          err_latched;
        t_out_word   step_q[$];

        function void clear_state();
            mode = M_IDLE;
            kw_progress = 0;
            kw_open = 3'b111;
            seg_start = 0;
            seg_len = 0;
            accum = 0;
            byte_pos = 0;
            err_latched = 0;
        endfunction

        function new();
            n_errors = 0;
            clear_state();
        endfunction

        function void push_token(logic [4:0] kind, logic [62:0] val, logic [15:0] st,
                                 logic [16:0] len, logic [1:0] cause);
            t_out_word w;
            if (step_q.size() >= 3) return;
            w.kind = kind;
            w.int_value = val;
            w.start_offset = st;
            w.ident_length = len;
            w.error_cause = cause;
            w.run_last = 1'b0;
            step_q.push_back(w);
        endfunction

        function void raise_error(logic [15:0] pos, logic [1:0] cause);
            push_token(K_ERR, '0, pos, '0, cause);
            err_latched = 1;
            mode = M_IDLE;
        endfunction

        static function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction
        static function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function void flush_token();
            case (mode)
                M_KW, M_ID: push_token(K_IDENT, '0, seg_start, seg_len, CAUSE_NONE);
                M_NUM:      push_token(K_ICON, accum, seg_start, '0, CAUSE_NONE);
                M_LT:       push_token(K_LT, '0, seg_start, '0, CAUSE_NONE);
                M_GT:       push_token(K_GT, '0, seg_start, '0, CAUSE_NONE);
                M_EQ:       push_token(K_ASGN, '0, seg_start, '0, CAUSE_NONE);
                M_BAR:      push_token(K_BOR, '0, seg_start, '0, CAUSE_NONE);
                M_AMP:      push_token(K_BAND, '0, seg_start, '0, CAUSE_NONE);
                M_BANG:     raise_error(seg_start, CAUSE_BANG);
                default: ;
            endcase
            mode = M_IDLE;
        endfunction

        function void open_token(logic [7:0] c, logic [15:0] pos);
            logic [4:0] single;
            bit         found;
            found = 1;
            single = K_ERR;
            seg_start = pos;
            if (c == " " || c == 8'h09 || c == 8'h0a) return;
            if (is_letter(c)) begin
                seg_len = 1;
                kw_progress = 1;
                if (c == "i") begin
                    kw_open = 3'b011;
                    mode = M_KW;
                end else if (c == "r") begin
                    kw_open = 3'b100;
                    mode = M_KW;
                end else begin
                    kw_open = 0;
                    mode = M_ID;
                end
                return;
            end
            if (is_digit(c)) begin
                accum = 63'(c - "0");
                mode = M_NUM;
                return;
            end
            case (c)
                "(": single = K_LPAR;
                ")": single = K_RPAR;
                "{": single = K_LBR;
                "}": single = K_RBR;
                "+": single = K_PLUS;
                "-": single = K_MINUS;
                "*": single = K_STAR;
                "/": single = K_SLASH;
                "%": single = K_PCT;
                "^": single = K_XOR;
                ";": single = K_SEMI;
                "<": mode = M_LT;
                ">": mode = M_GT;
                "=": mode = M_EQ;
                "!": mode = M_BANG;
                "|": mode = M_BAR;
                "&": mode = M_AMP;
                default: found = 0;
            endcase
            if (mode != M_IDLE) return;
            if (found) push_token(single, '0, pos, '0, CAUSE_NONE);
            else raise_error(pos, CAUSE_BYTE);
        endfunction

        // one keyword letter: returns 1 when the byte was consumed
        function bit keyword_letter(logic [7:0] c);
            string      kw_txt[3];
            int         kw_n[3];
            logic [2:0] keep;
            kw_txt = '{"int", "if", "return"};
            kw_n = '{3, 2, 6};
            keep = 0;
            for (int i = 0; i < 3; i++)
                if (kw_open[i] && kw_progress < kw_n[i] && kw_txt[i][kw_progress] == c)
                    keep[i] = 1;
            seg_len++;
            if (keep == 0) begin
                mode = M_ID;
                return 1;
            end
            kw_open = keep;
            kw_progress++;
            for (int i = 0; i < 3; i++)
                if (keep[i] && kw_n[i] == kw_progress) begin
                    push_token(5'(i), '0, seg_start, '0, CAUSE_NONE);
                    mode = M_IDLE;
                    return 1;
                end
            return 1;
        endfunction

        // pair with the pending operator byte, 1 when consumed
        function bit pair_op(logic [7:0] c, logic [7:0] c2, logic [4:0] kind);
            if (c != c2) return 0;
            push_token(kind, '0, seg_start, '0, CAUSE_NONE);
            mode = M_IDLE;
            return 1;
        endfunction

        function void lex_byte(logic [7:0] c, logic [15:0] pos);
            bit done;
            logic [62:0] d;
            done = 0;
            case (mode)
                M_KW: if (is_letter(c)) done = keyword_letter(c);
                M_ID: if (is_letter(c)) begin
                    if (seg_len < 17'd65536) seg_len++;
                    done = 1;
                end
                M_NUM: if (is_digit(c)) begin
                    d = 63'(c - "0");
                    if (accum > (VMAX - d) / 10) accum = VMAX;
                    else accum = accum * 10 + d;
                    done = 1;
                end
                M_LT: done = pair_op(c, "=", K_LE) || pair_op(c, "<", K_LSH);
                M_GT: done = pair_op(c, "=", K_GE) || pair_op(c, ">", K_RSH);
                M_EQ: done = pair_op(c, "=", K_EQ);
                M_BAR: done = pair_op(c, "|", K_LOR);
                M_AMP: done = pair_op(c, "&", K_LAND);
                M_BANG: begin
                    if (!pair_op(c, "=", K_NEQ)) raise_error(seg_start, CAUSE_BANG);
                    done = 1;
                end
                default: mode = M_IDLE;
            endcase
            if (done) return;
            flush_token();
            if (!err_latched) open_token(c, pos);
        endfunction

        // predict the tokens of one accepted byte
        function void note_byte(t_in_word w);
            logic [15:0] pos;
            pos = byte_pos;
            step_q.delete();
            if (!err_latched) lex_byte(w.ch, pos);
            byte_pos = pos + 1;
            if (w.last) begin
                if (!err_latched) flush_token();
                push_token(K_END, '0, byte_pos, '0, CAUSE_NONE);
                clear_state();
            end
            if (step_q.size() > 0) step_q[step_q.size() - 1].run_last = 1'b1;
            foreach (step_q[i]) pending_q.push_back(step_q[i]);
        endfunction

        function void report(string what, t_out_word got, t_out_word exp_w);
            n_errors++;
            $display("ERROR %0t: %s got k=%0d v=%0d s=%0d l=%0d c=%0d r=%0d exp k=%0d v=%0d s=%0d l=%0d c=%0d r=%0d",
                     $time, what, got.kind, got.int_value, got.start_offset,
                     got.ident_length, got.error_cause, got.run_last, exp_w.kind,
                     exp_w.int_value, exp_w.start_offset, exp_w.ident_length,
                     exp_w.error_cause, exp_w.run_last);
        endfunction

        function void check_token(t_out_word got);
            t_out_word exp_w;
            if (pending_q.size() == 0) begin
                report("unexpected token", got, '0);
                return;
            end
            exp_w = pending_q.pop_front();
            if (got.kind != exp_w.kind || got.int_value != exp_w.int_value ||
                got.start_offset != exp_w.start_offset ||
                got.ident_length != exp_w.ident_length ||
                got.error_cause != exp_w.error_cause || got.run_last != exp_w.run_last)
                report("token mismatch", got, exp_w);
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    t_in_word  i_in_word;
    logic      i_in_valid;
    logic      o_in_ready;
    t_out_word o_out_word;
    logic      o_out_valid;
    logic      i_out_ready;

    token_board board;
    int  send_idle_pct;
    int  recv_stall_pct;
    longint cycle_cnt;
    byte program_q[$];

    c_subset_lexer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_word  (o_out_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // sink side: random stall, check every accepted token
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) board.check_token(o_out_word);
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on a generous cycle budget
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 200000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // send one byte; gaps come before valid rises, never while it is up
    task automatic send_byte(byte c, bit fin);
        t_in_word w;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        w.ch = c;
        w.last = fin;
        i_in_word <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_byte(w);
    endtask

    task automatic send_program();
        foreach (program_q[i]) send_byte(program_q[i], i == program_q.size() - 1);
        program_q.delete();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) program_q.push_back(s[i]);
    endtask

    // random token text, mostly well formed
    task automatic add_random_token();
        string ops[] = '{"(", ")", "{", "}", "+", "-", "*", "/", "%", "^", ";", "<",
                         ">", "<=", ">=", "==", "!=", "||", "&&", "|", "&", "<<",
                         ">>", "=", "int", "if", "return", "intx", "re", "ifif"};
        string seps[] = '{" ", "\t", "\n"};
        int n;
        case ($urandom_range(9))
            0, 1, 2: add_text(ops[$urandom_range(ops.size() - 1)]);
            3, 4: begin
                n = $urandom_range(1, 6);
                repeat (n) program_q.push_back($urandom_range(1) ?
                    byte'($urandom_range("a", "z")) : byte'($urandom_range("A", "Z")));
            end
            5, 6: begin
                n = ($urandom_range(9) == 0) ? $urandom_range(19, 24) : $urandom_range(1, 5);
                repeat (n) program_q.push_back(byte'($urandom_range("0", "9")));
            end
            7, 8: add_text(seps[$urandom_range(2)]);
            default: begin
                if ($urandom_range(1)) program_q.push_back(byte'($urandom_range(1, 255)));
                else add_text("!");
            end
        endcase
    endtask

    initial begin
        board = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cycle_cnt = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: keywords, partial keywords, all operators, overflow, errors
        add_text("int if return intx ret iff(){}+-*/%^;< > <= >= == != || && | & << >> =x");
        add_text(" Zz 9223372036854775807 99999999999999999999");
        send_program();
        add_text("a!b");
        send_program();
        add_text("x");
        program_q.push_back(8'h80);
        add_text("y");
        send_program();
        add_text("<");
        send_program();
        program_q.push_back(8'hff);
        send_program();

        // random phases: idle levels for sender and receiver
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 62 : 29) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 62 : 29) : 0;
            for (int p = 0; p < 4; p++) begin
                repeat ($urandom_range(3, 11)) add_random_token();
                send_program();
            end
        end

        // drain
        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.n_errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
